### sv/bcpnn_pkg.sv
package bcpnn_pkg;

	localparam int FRAC_BITS = 16;
	localparam int LOG_FRAC = 24;
	localparam logic [16:0] ONE = 17'(1) << FRAC_BITS;
	localparam logic [29:0] LN2_Q30 = 30'd744261118;
	localparam int RND_SH = 30 + LOG_FRAC - FRAC_BITS;

	localparam int DIV_W = 44;
	localparam int DIV_STEP = 4;
	localparam int DIV_STAGES = DIV_W / DIV_STEP;
	localparam int MAG_W = 34;
	localparam int HALF_W = MAG_W / 2;

	localparam int ST_CN = DIV_STAGES + 1;
	localparam int ST_LOG0 = ST_CN + 1;
	localparam int ST_CMB = ST_LOG0 + LOG_FRAC;
	localparam int ST_MUL = ST_CMB + 1;
	localparam int ST_OUT = ST_MUL + 1;
	localparam int NSTAGE = ST_OUT + 1;

	localparam logic [1:0] REG_TAU = 2'd0;
	localparam logic [1:0] REG_CTHR = 2'd1;
	localparam logic [1:0] REG_BATCH = 2'd2;

	localparam int LN_CN = 0;
	localparam int LN_THR = 1;
	localparam int LN_CI = 2;
	localparam int LN_CJ = 3;

	localparam logic signed [23:0] W_MAX = 24'sh7FFFFF;
	localparam logic signed [23:0] W_MIN = 24'sh800000;

	typedef struct packed {
		logic [4:0]  e;
		logic [30:0] m;
		logic [23:0] frac;
	} lane_t;

	typedef struct packed {
		logic [32:0]            a;
		logic [DIV_W-1:0]       dq;
		logic [10:0]            rem;
		logic [10:0]            bt;
		logic [16:0]            ci;
		logic [16:0]            cj;
		logic [16:0]            cthr;
		logic [16:0]            cn;
		lane_t [3:0]            ln;
		logic                   neg;
		logic [MAG_W-1:0]       mag;
		logic [HALF_W+29:0]     plo;
		logic [HALF_W+29:0]     phi;
		logic signed [23:0]     weight;
	} item_t;

	function automatic lane_t lg_norm(logic [16:0] x);
		lane_t r;
		r.e = 5'd0;
		for (int i = 1; i < 17; i++) begin
			if (x[i]) begin
				r.e = 5'(i);
			end
		end
		r.m = 31'({14'd0, x}) << (5'd30 - r.e);
		r.frac = 24'd0;
		return r;
	endfunction

	function automatic lane_t lg_step(lane_t l);
		lane_t r;
		logic [61:0] p;
		r = l;
		p = 62'(l.m) * 62'(l.m);
		if (p[61]) begin
			r.m = p[61:31];
			r.frac = {l.frac[22:0], 1'b1};
		end else begin
			r.m = p[60:30];
			r.frac = {l.frac[22:0], 1'b0};
		end
		return r;
	endfunction

	function automatic item_t div_step(item_t p);
		item_t r;
		logic [11:0] t;
		r = p;
		for (int i = 0; i < DIV_STEP; i++) begin
			t = {r.rem, r.dq[DIV_W-1]};
			r.dq = r.dq << 1;
			if (t >= 12'(r.bt)) begin
				r.rem = 11'(t - 12'(r.bt));
				r.dq[0] = 1'b1;
			end else begin
				r.rem = t[10:0];
			end
		end
		return r;
	endfunction

endpackage

### sv/bcpnn_weight_trace_update.sv
// Joint probability trace and log-ratio weight for a stream of synapse elements.
// Input channel: in_valid / in_stall carry cij_old, coact_sum, ci, cj as one beat.
// Output channel: out_valid / out_stall carry cij_new and weight as one beat.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 tau,
// 1 cthr, 2 batch_total); other indexes are ignored. Write only while idle.
// Throughput: one beat per cycle while the receiver does not stall. A beat
// passes an entry stage that forms the trace products, the 11 stages of the
// 4-bit-per-stage quotient of tau*coact_sum by batch_total, one stage that
// rounds the trace and normalizes the log inputs, the 24 squaring stages of
// the log (one 31x31 multiply each, four lanes side by side) and 3 stages
// that combine the logs, apply the ln2 scaling, and round and saturate.
// When the receiver stalls with a beat waiting, the whole pipeline holds and
// in_stall rises in the same cycle; nothing is lost or repeated.
// Reset clears all valid bits and loads tau 655, cthr 6, batch_total 1.
module bcpnn_weight_trace_update import bcpnn_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [16:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [16:0]        cij_old,
	input  logic [26:0]        coact_sum,
	input  logic [16:0]        ci,
	input  logic [16:0]        cj,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [16:0]        cij_new,
	output logic signed [23:0] weight
);

	logic [16:0] tau_q;
	logic [16:0] cthr_q;
	logic [10:0] bt_q;

	logic              adv;
	logic [NSTAGE-1:0] vld_s;
	item_t             pipe_s [NSTAGE];
	item_t             stg_d [NSTAGE];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tau_q <= 17'd655;
			cthr_q <= 17'd6;
			bt_q <= 11'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TAU:   tau_q <= cfg_data;
				REG_CTHR:  cthr_q <= cfg_data;
				REG_BATCH: bt_q <= cfg_data[10:0];
				default:   ;
			endcase
		end
	end

	assign adv = !(vld_s[NSTAGE-1] && out_stall);
	assign in_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[NSTAGE-2:0], in_valid};
		end
	end

	for (genvar k = 0; k < NSTAGE; k++) begin : g_stage
		if (k == 0) begin : g_entry
			always_comb begin
				logic [16:0] t;
				logic [16:0] omt;
				stg_d[k] = '0;
				t = (tau_q > ONE) ? ONE : tau_q;
				omt = ONE - t;
				stg_d[k].a = 33'(34'(omt) * 34'(cij_old));
				stg_d[k].dq = 44'(t) * 44'(coact_sum);
				stg_d[k].rem = '0;
				stg_d[k].bt = (bt_q == 11'd0) ? 11'd1 : bt_q;
				stg_d[k].ci = ci;
				stg_d[k].cj = cj;
				stg_d[k].cthr = cthr_q;
			end
		end else if (k <= DIV_STAGES) begin : g_div
			always_comb begin
				stg_d[k] = div_step(pipe_s[k-1]);
			end
		end else if (k == ST_CN) begin : g_cn
			always_comb begin
				logic [44:0] s;
				logic [28:0] hi;
				stg_d[k] = pipe_s[k-1];
				s = 45'(pipe_s[k-1].a) + 45'(ONE >> 1) + 45'(pipe_s[k-1].dq);
				hi = 29'(s >> FRAC_BITS);
				stg_d[k].cn = (|hi[28:17]) ? 17'h1FFFF : hi[16:0];
				stg_d[k].ln[LN_CN] = lg_norm(stg_d[k].cn);
				stg_d[k].ln[LN_THR] = lg_norm(pipe_s[k-1].cthr);
				stg_d[k].ln[LN_CI] = lg_norm(pipe_s[k-1].ci);
				stg_d[k].ln[LN_CJ] = lg_norm(pipe_s[k-1].cj);
			end
		end else if (k < ST_CMB) begin : g_log
			always_comb begin
				stg_d[k] = pipe_s[k-1];
				for (int l = 0; l < 4; l++) begin
					stg_d[k].ln[l] = lg_step(pipe_s[k-1].ln[l]);
				end
			end
		end else if (k == ST_CMB) begin : g_cmb
			always_comb begin
				logic signed [35:0] fl;
				logic signed [35:0] l_cn;
				logic signed [35:0] l_th;
				logic signed [35:0] l_ci;
				logic signed [35:0] l_cj;
				logic signed [35:0] nl_a;
				logic signed [35:0] c4;
				logic signed [35:0] nl;
				logic signed [35:0] tl;
				logic signed [35:0] at;
				item_t p;
				p = pipe_s[k-1];
				stg_d[k] = p;
				fl = 36'(FRAC_BITS) << LOG_FRAC;
				l_cn = $signed({7'd0, p.ln[LN_CN].e, p.ln[LN_CN].frac});
				l_th = $signed({7'd0, p.ln[LN_THR].e, p.ln[LN_THR].frac});
				l_ci = $signed({7'd0, p.ln[LN_CI].e, p.ln[LN_CI].frac});
				l_cj = $signed({7'd0, p.ln[LN_CJ].e, p.ln[LN_CJ].frac});
				nl_a = l_cn - fl;
				c4 = (l_th <<< 2) - (fl <<< 2);
				nl = nl_a;
				if (p.cthr != 17'd0 && (p.cn == 17'd0 || c4 > nl_a)) begin
					nl = c4;
				end
				tl = nl - l_ci - l_cj + (fl <<< 1);
				at = tl[35] ? -tl : tl;
				stg_d[k].neg = tl[35];
				stg_d[k].mag = at[MAG_W-1:0];
			end
		end else if (k == ST_MUL) begin : g_mul
			always_comb begin
				stg_d[k] = pipe_s[k-1];
				stg_d[k].plo = (HALF_W + 30)'(pipe_s[k-1].mag[HALF_W-1:0])
					* (HALF_W + 30)'(LN2_Q30);
				stg_d[k].phi = (HALF_W + 30)'(pipe_s[k-1].mag[MAG_W-1:HALF_W])
					* (HALF_W + 30)'(LN2_Q30);
			end
		end else begin : g_out
			always_comb begin
				logic [63:0] pm;
				logic [25:0] r;
				item_t p;
				p = pipe_s[k-1];
				stg_d[k] = p;
				pm = (64'(p.phi) << HALF_W) + 64'(p.plo);
				r = 26'((pm + (64'd1 << (RND_SH - 1))) >> RND_SH);
				if (p.ci < p.cthr || p.cj < p.cthr) begin
					stg_d[k].weight = '0;
				end else if (p.cn == 17'd0 && p.cthr == 17'd0) begin
					stg_d[k].weight = W_MIN;
				end else if (p.ci == 17'd0 || p.cj == 17'd0) begin
					stg_d[k].weight = W_MAX;
				end else if (p.neg) begin
					stg_d[k].weight = (r > 26'd8388608) ? W_MIN : 24'(26'd0 - r);
				end else begin
					stg_d[k].weight = (r > 26'd8388607) ? W_MAX : 24'(r);
				end
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				pipe_s[k] <= stg_d[k];
			end
		end
	end

	assign out_valid = vld_s[NSTAGE-1];
	assign cij_new = pipe_s[NSTAGE-1].cn;
	assign weight = pipe_s[NSTAGE-1].weight;

	a_bt_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[0] |-> pipe_s[0].bt != 11'd0)
		else $error("divisor zero in pipeline");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[DIV_STAGES] |-> pipe_s[DIV_STAGES].rem < pipe_s[DIV_STAGES].bt)
		else $error("remainder not below divisor");

	a_mant_norm: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[ST_CMB-1] && pipe_s[ST_CMB-1].ci != 17'd0
		|-> pipe_s[ST_CMB-1].ln[LN_CI].m[30])
		else $error("log mantissa lost normalization");

	a_hold_entry: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[0] && !adv |=> vld_s[0])
		else $error("held beat dropped from first stage");

endmodule
